### rtl/unf_pkg.sv
// Shared types and constants for the unterminated note finder.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package unf_pkg;

    localparam logic [7:0] MSK_TYPE      = 8'hF0;
    localparam logic [7:0] MSK_CHAN      = 8'h0F;
    localparam logic [7:0] TYPE_NOTE_ON  = 8'h90;
    localparam logic [7:0] TYPE_NOTE_OFF = 8'h80;

    localparam int KEY_W = 12;

    // result queue
    localparam int RQ_DEPTH = 4;
    localparam int RQ_AW    = 2;
    localparam int RQ_CW    = 3;

    typedef struct packed {
        logic [7:0]  status;
        logic [7:0]  data1;
        logic [7:0]  data2;
        logic [31:0] time_tag;
    } t_entry;

    typedef struct packed {
        t_entry msg;
        logic   final_res;
        logic   none_found;
        logic   overflowed;
    } t_res;

    // set handed from front to back
    typedef struct packed {
        logic vld;
        logic drop;
    } t_set_ctl;

endpackage

`default_nettype wire

### rtl/unf_front.sv
// Front end: loads messages into the store, tracks open note-ons per entry.
// Depends on unf_pkg. Hands a finished set to unf_back.
`timescale 1ns / 1ps
`default_nettype none

module unf_front
    import unf_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         push,
    output logic                              full,
    input  wire t_entry                       i_msg,
    input  wire logic                         i_last,
    input  wire logic                         i_back_busy,
    input  wire logic                         i_take,
    output t_set_ctl                          o_ctl,
    output logic [$clog2(DEPTH+1)-1:0]        o_cnt,
    output logic [DEPTH-1:0]                  o_pend,
    input  wire logic                         i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]     i_rd_addr,
    output t_entry                            o_rd_data
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    t_entry            r_mem [DEPTH];
    logic [KEY_W-1:0]  r_key [DEPTH];
    t_entry            r_rd_data;

    logic [CW-1:0]     r_cnt, n_cnt;
    logic              r_drop, n_drop;
    logic [DEPTH-1:0]  r_pend, n_pend;

    logic              r_desc_vld;
    logic              r_desc_drop;
    logic [CW-1:0]     r_desc_cnt;
    logic [DEPTH-1:0]  r_desc_pend;

    logic              accept;
    logic              room;
    logic [AW-1:0]     wr_idx;
    logic [7:0]        msg_type;
    logic              is_live;
    logic              is_ender;
    logic [KEY_W-1:0]  msg_key;
    logic [7:0]        msg_chan;

    assign full     = r_desc_vld | i_back_busy;
    assign accept   = push & ~full;
    assign room     = r_cnt < CW'(DEPTH);
    assign wr_idx   = r_cnt[AW-1:0];
    assign msg_type = i_msg.status & MSK_TYPE;
    assign msg_chan = i_msg.status & MSK_CHAN;
    assign msg_key  = KEY_W'({msg_chan, i_msg.data1});
    assign is_live  = (msg_type == TYPE_NOTE_ON) && (i_msg.data2 != 8'd0);
    assign is_ender = (msg_type == TYPE_NOTE_OFF) ||
                      ((msg_type == TYPE_NOTE_ON) && (i_msg.data2 == 8'd0));

    always_comb begin
        n_pend = r_pend;
        n_cnt  = r_cnt;
        n_drop = r_drop;
        if (accept) begin
            if (room) begin
                n_cnt = r_cnt + CW'(1);
                for (int i = 0; i < DEPTH; i++) begin
                    if (AW'(i) == wr_idx) begin
                        n_pend[i] = is_live;
                    end else if (r_pend[i] && is_ender && (r_key[i] == msg_key)) begin
                        n_pend[i] = 1'b0;
                    end
                end
            end else begin
                n_drop = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_drop     <= 1'b0;
            r_pend     <= '0;
            r_desc_vld <= 1'b0;
        end else begin
            if (i_take) begin
                r_desc_vld <= 1'b0;
            end
            if (accept && i_last) begin
                r_desc_vld <= 1'b1;
                r_cnt      <= '0;
                r_drop     <= 1'b0;
                r_pend     <= '0;
            end else begin
                r_cnt  <= n_cnt;
                r_drop <= n_drop;
                r_pend <= n_pend;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && i_last) begin
            r_desc_cnt  <= n_cnt;
            r_desc_drop <= n_drop;
            r_desc_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && room) begin
            r_mem[wr_idx] <= i_msg;
            r_key[wr_idx] <= msg_key;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_ctl.vld  = r_desc_vld;
    assign o_ctl.drop = r_desc_drop;
    assign o_cnt      = r_desc_cnt;
    assign o_pend     = r_desc_pend;
    assign o_rd_data  = r_rd_data;

endmodule

`default_nettype wire

### rtl/unf_back.sv
// Back end: walks the store of a finished set and emits open note-ons in order.
// Depends on unf_pkg; reads the store of unf_front, writes into unf_rq.
`timescale 1ns / 1ps
`default_nettype none

module unf_back
    import unf_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire t_set_ctl                     i_ctl,
    input  wire logic [$clog2(DEPTH+1)-1:0]   i_cnt,
    input  wire logic [DEPTH-1:0]             i_pend,
    output logic                              o_take,
    output logic                              o_busy,
    output logic                              o_rd_en,
    output logic [$clog2(DEPTH)-1:0]          o_rd_addr,
    input  wire t_entry                       i_rd_data,
    input  wire logic [RQ_CW-1:0]             i_level,
    output logic                              o_push,
    output t_res                              o_res
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    logic              r_active;
    logic [CW-1:0]     r_idx;
    logic [CW-1:0]     r_cnt;
    logic [DEPTH-1:0]  r_pend;
    logic              r_drop;
    logic              r_rdv;
    t_entry            r_hold;
    logic              r_hold_vld;

    logic              scan_more;
    logic              idx_pend;
    logic              room_ok;
    logic              step;
    logic              finish;
    logic [RQ_CW-1:0]  lvl_sum;

    assign o_take    = i_ctl.vld & ~r_active;
    assign o_busy    = r_active;
    assign scan_more = r_idx < r_cnt;
    assign idx_pend  = r_pend[r_idx[AW-1:0]];
    assign lvl_sum   = i_level + RQ_CW'(r_rdv);
    assign room_ok   = lvl_sum < RQ_CW'(RQ_DEPTH);
    assign o_rd_en   = r_active & scan_more & idx_pend & room_ok;
    assign o_rd_addr = r_idx[AW-1:0];
    assign step      = r_active & scan_more & (~idx_pend | room_ok);
    assign finish    = r_active & ~scan_more & ~r_rdv & room_ok;

    // one note is held back so the final flag is known when it leaves
    always_comb begin
        o_push           = 1'b0;
        o_res.msg        = r_hold;
        o_res.final_res  = 1'b0;
        o_res.none_found = 1'b0;
        o_res.overflowed = r_drop;
        if (r_rdv && r_hold_vld) begin
            o_push = 1'b1;
        end else if (finish) begin
            o_push          = 1'b1;
            o_res.final_res = 1'b1;
            if (!r_hold_vld) begin
                o_res.msg        = '0;
                o_res.none_found = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_rdv      <= 1'b0;
            r_hold_vld <= 1'b0;
            r_idx      <= '0;
        end else begin
            if (o_take) begin
                r_active   <= 1'b1;
                r_idx      <= '0;
                r_rdv      <= 1'b0;
                r_hold_vld <= 1'b0;
            end else begin
                r_rdv <= o_rd_en;
                if (step) begin
                    r_idx <= r_idx + CW'(1);
                end
                if (r_rdv) begin
                    r_hold_vld <= 1'b1;
                end
                if (finish) begin
                    r_active <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_cnt  <= i_cnt;
            r_pend <= i_pend;
            r_drop <= i_ctl.drop;
        end
        if (r_rdv) begin
            r_hold <= i_rd_data;
        end
    end

endmodule

`default_nettype wire

### rtl/unf_rq.sv
// Result queue: small FIFO of result beats in front of the output port.
// Depends on unf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module unf_rq
    import unf_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire t_res              i_res,
    output logic [RQ_CW-1:0]       o_level,
    output logic                   empty,
    input  wire logic              pop,
    output t_res                   o_res
);

    t_res              r_buf [RQ_DEPTH];
    logic [RQ_AW-1:0]  r_wp;
    logic [RQ_AW-1:0]  r_rp;
    logic [RQ_CW-1:0]  r_cnt;
    logic              deq;

    assign empty   = (r_cnt == '0);
    assign deq     = pop & ~empty;
    assign o_level = r_cnt;
    assign o_res   = r_buf[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + RQ_AW'(1);
            end
            if (deq) begin
                r_rp <= r_rp + RQ_AW'(1);
            end
            r_cnt <= r_cnt + RQ_CW'(i_push) - RQ_CW'(deq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_res;
        end
    end

endmodule

`default_nettype wire

### rtl/unterminated_note_finder.sv
// Top level of the unterminated note finder: front loader, back scanner, result queue.
// Depends on unf_pkg, unf_front, unf_back, unf_rq.
//
//   channel  | handshake          | beat
//   ---------+--------------------+--------------------------------------------------
//   input    | push / full        | i_status, i_data1, i_data2, i_time_tag, i_last
//   result   | pop / empty        | o_out_status .. o_out_time_tag, flags
//
// Messages load one per cycle while full is low; each stored one updates all open-note flags.
// After the last beat the scanner walks the store, one entry per cycle while the result queue
// has room; full stays high from the last beat until that walk ends.
// Results queue in a four-beat FIFO; a stalled pop stalls the walk only when it fills.
// Reset is synchronous and clears the count, flags and queue; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module unterminated_note_finder
    import unf_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         push,
    output logic              full,
    input  wire logic [7:0]   i_status,
    input  wire logic [7:0]   i_data1,
    input  wire logic [7:0]   i_data2,
    input  wire logic [31:0]  i_time_tag,
    input  wire logic         i_last,
    output logic              empty,
    input  wire logic         pop,
    output logic [7:0]        o_out_status,
    output logic [7:0]        o_out_pitch,
    output logic [7:0]        o_out_velocity,
    output logic [31:0]       o_out_time_tag,
    output logic              o_final_res,
    output logic              o_none_found,
    output logic              o_overflowed
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH+1);

    t_entry            in_msg;
    t_set_ctl          set_ctl;
    logic [CW-1:0]     set_cnt;
    logic [DEPTH-1:0]  set_pend;
    logic              take;
    logic              back_busy;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    t_entry            rd_data;
    logic [RQ_CW-1:0]  q_level;
    logic              q_push;
    t_res              q_in;
    t_res              q_out;

    assign in_msg.status   = i_status;
    assign in_msg.data1    = i_data1;
    assign in_msg.data2    = i_data2;
    assign in_msg.time_tag = i_time_tag;

    unf_front #(.DEPTH(DEPTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_msg       (in_msg),
        .i_last      (i_last),
        .i_back_busy (back_busy),
        .i_take      (take),
        .o_ctl       (set_ctl),
        .o_cnt       (set_cnt),
        .o_pend      (set_pend),
        .i_rd_en     (rd_en),
        .i_rd_addr   (rd_addr),
        .o_rd_data   (rd_data)
    );

    unf_back #(.DEPTH(DEPTH)) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (set_ctl),
        .i_cnt     (set_cnt),
        .i_pend    (set_pend),
        .o_take    (take),
        .o_busy    (back_busy),
        .o_rd_en   (rd_en),
        .o_rd_addr (rd_addr),
        .i_rd_data (rd_data),
        .i_level   (q_level),
        .o_push    (q_push),
        .o_res     (q_in)
    );

    unf_rq u_rq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_res   (q_in),
        .o_level (q_level),
        .empty   (empty),
        .pop     (pop),
        .o_res   (q_out)
    );

    assign o_out_status   = q_out.msg.status;
    assign o_out_pitch    = q_out.msg.data1;
    assign o_out_velocity = q_out.msg.data2;
    assign o_out_time_tag = q_out.msg.time_tag;
    assign o_final_res    = q_out.final_res;
    assign o_none_found   = q_out.none_found;
    assign o_overflowed   = q_out.overflowed;

endmodule

`default_nettype wire
